@@ design/sfm_pkg.sv @@
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants for the substring first-match search block.
// ----------------------------------------------------------------------------
package sfm_pkg;

	localparam int CP_W      = 21;
	localparam int RES_POS_W = 16;
	localparam int START_W   = 16;

	typedef enum logic {
		OP_PATTERN = 1'b0,
		OP_TEXT    = 1'b1
	} op_t;

	// control shared by every cell of the chain
	typedef struct packed {
		logic shift_pat;
		logic shift_txt;
		logic clr_txt;
		logic eval;
	} cell_ctrl_t;

	// record of one accepted item handed to the collect stage
	typedef struct packed {
		logic                 valid;
		logic                 clr;
		logic                 ovf;
		logic                 qual;
		logic                 last;
		logic [RES_POS_W-1:0] start;
	} stage_t;

endpackage

@@ design/sfm_in_if.sv @@
// ----------------------------------------------------------------------------
// sfm_in_if
// Input channel: pattern or text codepoint items with valid/ready.
// ----------------------------------------------------------------------------
interface sfm_in_if import sfm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            op;
	logic [CP_W-1:0] codepoint;
	logic            last;

	modport source (output valid, op, codepoint, last, input ready);
	modport sink (input valid, op, codepoint, last, output ready);
endinterface

@@ design/sfm_out_if.sv @@
// ----------------------------------------------------------------------------
// sfm_out_if
// Result channel: found flag, match position and overflow with valid/ready.
// ----------------------------------------------------------------------------
interface sfm_out_if import sfm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [RES_POS_W-1:0] position;
	logic                 overflow;

	modport source (output valid, found, position, overflow, input ready);
	modport sink (input valid, found, position, overflow, output ready);
endinterface

@@ design/sfm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sfm_cfg_if
// Configuration write channel carrying the start index register.
// ----------------------------------------------------------------------------
interface sfm_cfg_if import sfm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [START_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ design/sfm_cell.sv @@
// ----------------------------------------------------------------------------
// sfm_cell
// One cell of the compare chain: holds one pattern and one window codepoint,
// passes both to its neighbor and registers their compare result.
// ----------------------------------------------------------------------------
module sfm_cell import sfm_pkg::*; (
	input  logic            clk,
	input  cell_ctrl_t      ctrl,
	input  logic            active,
	input  logic [CP_W-1:0] pat_in,
	input  logic [CP_W-1:0] txt_in,
	output logic [CP_W-1:0] pat_out,
	output logic [CP_W-1:0] txt_out,
	output logic            eq_s1
);

	logic [CP_W-1:0] pat_q;
	logic [CP_W-1:0] txt_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_pat) begin
			pat_q <= pat_in;
		end
		if (ctrl.clr_txt) begin
			txt_q <= '0;
		end else if (ctrl.shift_txt) begin
			txt_q <= txt_in;
		end
		// compare against the codepoint entering this cell
		if (ctrl.eval) begin
			eq_s1 <= !active || (pat_q == txt_in);
		end
	end

	assign pat_out = pat_q;
	assign txt_out = txt_q;

endmodule

@@ design/sfm_collect.sv @@
// ----------------------------------------------------------------------------
// sfm_collect
// Reduces the cell compares, keeps the first match and overflow state and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module sfm_collect import sfm_pkg::*; #(
	parameter int NCELL = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stage_t           st_s1,
	input  logic [NCELL-1:0] eq_s1,
	output logic             stall,
	sfm_out_if.source        result
);

	logic                 match_q;
	logic [RES_POS_W-1:0] mpos_q;
	logic                 ovf_q;
	logic                 valid_q;
	logic                 found_q;
	logic [RES_POS_W-1:0] position_q;
	logic                 overflow_q;

	logic                 m0;
	logic                 hit;
	logic                 m1;
	logic [RES_POS_W-1:0] p1;
	logic                 o1;
	logic                 go;

	always_comb begin
		m0    = st_s1.clr ? 1'b0 : match_q;
		o1    = (st_s1.clr ? 1'b0 : ovf_q) | st_s1.ovf;
		hit   = st_s1.qual & (&eq_s1);
		m1    = m0 | hit;
		p1    = m0 ? mpos_q : st_s1.start;
		stall = st_s1.valid & st_s1.last & valid_q & !result.ready;
		go    = st_s1.valid & !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			ovf_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && result.ready) begin
				valid_q <= 1'b0;
			end
			if (go) begin
				if (st_s1.last) begin
					valid_q <= 1'b1;
					match_q <= 1'b0;
					ovf_q   <= 1'b0;
				end else begin
					match_q <= m1;
					ovf_q   <= o1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mpos_q <= p1;
			if (st_s1.last) begin
				found_q    <= m1;
				position_q <= m1 ? p1 : '0;
				overflow_q <= o1;
			end
		end
	end

	assign result.valid    = valid_q;
	assign result.found    = found_q;
	assign result.position = position_q;
	assign result.overflow = overflow_q;

endmodule

@@ design/substring_first_match.sv @@
// the last text item is registered with the cell compares, then its result in the output register
// throughput: one item per cycle; input stalls only while a finished result waits
//   and the item behind it also ends a search
// the cell chain compares every pattern position against the text window in parallel
// reset: empty pattern, search state cleared, start index 0, no result pending
// ----------------------------------------------------------------------------
// substring_first_match
// Streams pattern and text codepoints through a chain of compare cells and
// reports the first match at or after the start index.
// ----------------------------------------------------------------------------
module substring_first_match import sfm_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	sfm_cfg_if.sink cfg,
	sfm_in_if.sink  item,
	sfm_out_if.source result
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int POS_W = $clog2(MAX_TEXT + 1);
	localparam int SW    = (POS_W > RES_POS_W + 1) ? POS_W : RES_POS_W + 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT);

	logic [START_W-1:0] start_q;
	logic [LEN_W-1:0]   len_q;
	logic               closed_q;
	logic [POS_W-1:0]   pos_q;
	stage_t             st_s1;

	logic               accept;
	logic               is_text;
	logic               new_pat;
	logic [LEN_W-1:0]   len_base;
	logic               pat_room;
	logic               txt_room;
	logic [POS_W-1:0]   pos_inc;
	logic [SW-1:0]      pos_ext;
	logic [SW-1:0]      len_ext;
	logic [SW-1:0]      s_ext;
	logic               qual;
	logic               stall;
	cell_ctrl_t         ctrl;
	stage_t             rec;

	logic [CP_W-1:0]        pat_link [MAX_PATTERN+1];
	logic [CP_W-1:0]        txt_link [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] active;
	logic [MAX_PATTERN-1:0] eq_s1;

	assign cfg.ready  = 1'b1;
	assign item.ready = !stall;

	always_comb begin
		accept   = item.valid & item.ready;
		is_text  = (item.op == OP_TEXT);
		new_pat  = !is_text && (closed_q || (pos_q != '0));
		len_base = new_pat ? '0 : len_q;
		pat_room = (len_base < LEN_MAX);
		txt_room = (pos_q < POS_MAX);
		pos_inc  = pos_q + POS_W'(1);
		pos_ext  = SW'(pos_inc);
		len_ext  = SW'(len_q);
		s_ext    = pos_ext - len_ext;
		qual     = txt_room && (len_q != '0) && (pos_ext >= len_ext)
			&& (s_ext >= SW'(start_q)) && (s_ext[SW-1:RES_POS_W] == '0);

		ctrl.shift_pat = accept & !is_text & pat_room;
		ctrl.shift_txt = accept & is_text & txt_room;
		ctrl.eval      = accept & is_text & txt_room;
		ctrl.clr_txt   = accept & (new_pat | (is_text & item.last));

		rec.valid = accept;
		rec.clr   = accept & new_pat;
		rec.ovf   = accept & ((!is_text & !pat_room) | (is_text & !txt_room));
		rec.qual  = accept & is_text & qual;
		rec.last  = accept & is_text & item.last;
		rec.start = s_ext[RES_POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			len_q    <= '0;
			closed_q <= 1'b1;
			pos_q    <= '0;
			st_s1    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				start_q <= cfg.data;
			end
			if (!stall) begin
				st_s1 <= rec;
			end
			if (accept) begin
				if (!is_text) begin
					closed_q <= 1'b0;
					len_q    <= pat_room ? len_base + LEN_W'(1) : len_base;
					if (new_pat) begin
						pos_q <= '0;
					end
				end else if (item.last) begin
					closed_q <= 1'b1;
					pos_q    <= '0;
				end else if (txt_room) begin
					pos_q <= pos_inc;
				end
			end
		end
	end

	assign pat_link[0] = item.codepoint;
	assign txt_link[0] = item.codepoint;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		assign active[j] = (LEN_W'(j) < len_q);

		sfm_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.active  (active[j]),
			.pat_in  (pat_link[j]),
			.txt_in  (txt_link[j]),
			.pat_out (pat_link[j+1]),
			.txt_out (txt_link[j+1]),
			.eq_s1   (eq_s1[j])
		);
	end

	sfm_collect #(
		.NCELL (MAX_PATTERN)
	) u_collect (
		.clk    (clk),
		.arst_n (arst_n),
		.st_s1  (st_s1),
		.eq_s1  (eq_s1),
		.stall  (stall),
		.result (result)
	);

endmodule
